>>> src/fdfp_pkg.sv
package fdfp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 24;

   localparam int FIELD_BITS = 24;
   localparam int VALUE_BITS = 64;

   localparam logic [7:0] CH_TERM = 8'h00;
   localparam logic [7:0] CH_LITTLE = "<";
   localparam logic [7:0] CH_BANG = "!";
   localparam logic [7:0] CH_BIG = ">";
   localparam logic [7:0] CH_PAD = "x";
   localparam logic [7:0] CH_STRING = "s";
   localparam logic [7:0] CH_ZERO = "0";
   localparam logic [7:0] CH_NINE = "9";
   localparam logic [3:0] DIGIT_BASE = 4'd10;

   typedef enum logic {
      OP_FORMAT = 1'b0,
      OP_VALUE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_EMPTY       = 3'd1,
      ERR_BAD_COUNT   = 3'd2,
      ERR_BAD_TYPE    = 3'd3,
      ERR_OVERFLOW    = 3'd4,
      ERR_OUT_OF_TURN = 3'd5
   } err_type;

   typedef enum logic [2:0] {
      PH_FORMAT  = 3'b001,
      PH_VALUES  = 3'b010,
      PH_DISCARD = 3'b100
   } phase_type;

   typedef struct packed {
      logic                  op;
      logic [7:0]            char_code;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] offset;
      logic [FIELD_BITS-1:0] length;
      logic [VALUE_BITS-1:0] data;
      err_type               error_code;
   } rsp_type;

   function automatic logic [3:0] type_size(input logic [7:0] c);
      logic [3:0] size;
      case (c) inside
         "x", "s", "b", "B":           size = 4'd1;
         "h", "H":                     size = 4'd2;
         "i", "I", "l", "L", "f":      size = 4'd4;
         "q", "Q", "d":                size = 4'd8;
         default:                      size = 4'd0;
      endcase
      return size;
   endfunction

endpackage

>>> src/format_driven_field_packer.sv
// Channel   Direction  Ports                Word
// req       in         req_valid/req_ready  op, char_code, value
// rsp       out        rsp_valid/rsp_ready  kind, offset, length, data, error_code
// csr       in         csr_valid/csr_ready  buffer_bytes
//
// One word is taken every cycle unless a stalled result holds the pipeline. The input register
// feeds one pass of format logic that updates the packer state and, when the word yields a result,
// loads the result register. Reset clears the state to the start of a format, big endian, and
// buffer_bytes to zero. A stalled result holds the pipeline; an empty input register still fills.
module format_driven_field_packer #(
   parameter int OFFSET_BITS = fdfp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [7:0]                          req_char_code,
   input  logic [fdfp_pkg::VALUE_BITS-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [fdfp_pkg::FIELD_BITS-1:0]     rsp_offset,
   output logic [fdfp_pkg::FIELD_BITS-1:0]     rsp_length,
   output logic [fdfp_pkg::VALUE_BITS-1:0]     rsp_data,
   output logic [2:0]                          rsp_error_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fdfp_pkg::FIELD_BITS-1:0]     csr_buffer_bytes
);
   import fdfp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_word_ff;
   logic [FIELD_BITS-1:0] buffer_ff;
   logic                  out_free;
   logic                  process;
   logic                  emit;
   rsp_type               word;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || process;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_free ? (process && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         buffer_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            buffer_ff <= csr_buffer_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= '{op: req_op, char_code: req_char_code, value: req_value};
      end
      if (process && emit) begin
         rsp_word_ff <= word;
      end
   end

   fdfp_engine #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (process),
      .item         (in_word_ff),
      .buffer_bytes (buffer_ff),
      .emit         (emit),
      .word         (word)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_word_ff.kind;
   assign rsp_offset     = rsp_word_ff.offset;
   assign rsp_length     = rsp_word_ff.length;
   assign rsp_data       = rsp_word_ff.data;
   assign rsp_error_code = rsp_word_ff.error_code;

`ifndef ASSERT_OFF
   a_err_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("error code set on a result that is not an error");

   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_offset == '0 && rsp_data == '0)
      else $error("done result carries offset or data");

   a_data_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |->
         (rsp_length == 24'd1 || rsp_length == 24'd2 || rsp_length == 24'd4 ||
          rsp_length == 24'd8))
      else $error("data write with an element size that no type has");
`endif

endmodule

>>> src/fdfp_engine.sv
module fdfp_engine #(
   parameter int OFFSET_BITS = fdfp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  fdfp_pkg::req_type                   item,
   input  logic [fdfp_pkg::FIELD_BITS-1:0]     buffer_bytes,
   output logic                                emit,
   output fdfp_pkg::rsp_type                   word
);
   import fdfp_pkg::*;

   localparam int RCW = OFFSET_BITS + 1;
   localparam int NCW = OFFSET_BITS + 5;
   localparam int CW = (OFFSET_BITS > FIELD_BITS ? OFFSET_BITS : FIELD_BITS) + 4;
   localparam logic [RCW-1:0] CNT_SAT = RCW'(1) << OFFSET_BITS;
   localparam logic [CW-1:0] OFF_MAX = (CW'(1) << OFFSET_BITS) - CW'(1);

   phase_type              phase_ff, phase_in;
   logic                   little_ff, little_in;
   logic [RCW-1:0]         count_ff, count_in;
   logic                   seen_ff, seen_in;
   logic [OFFSET_BITS-1:0] pend_ff, pend_in;
   logic [3:0]             ebytes_ff, ebytes_in;
   logic [OFFSET_BITS-1:0] woff_ff, woff_in;
   logic                   first_ff, first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FORMAT;
         little_ff <= 1'b0;
         count_ff  <= '0;
         seen_ff   <= 1'b0;
         pend_ff   <= '0;
         ebytes_ff <= '0;
         woff_ff   <= '0;
         first_ff  <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         little_ff <= little_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
         ebytes_ff <= ebytes_in;
         woff_ff   <= woff_in;
         first_ff  <= first_in;
      end
   end

   always_comb begin
      logic                   term;
      logic                   go_new;
      logic                   go_fail;
      logic                   fail_term;
      err_type                fail_code;
      logic [NCW-1:0]         next_count;
      logic [RCW-1:0]         count;
      logic [3:0]             esz;
      logic [1:0]             shift;
      logic [CW-1:0]          limit;
      logic [CW-1:0]          size;
      logic [CW-1:0]          reach;
      logic [OFFSET_BITS-1:0] pend_dec;
      logic [VALUE_BITS-1:0]  bytes;
      logic [2:0]             src;

      phase_in  = phase_ff;
      little_in = little_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      ebytes_in = ebytes_ff;
      woff_in   = woff_ff;
      first_in  = first_ff;
      emit      = 1'b0;
      word      = '{kind: KIND_DATA, offset: '0, length: '0, data: '0,
                    error_code: ERR_NONE};
      term      = (item.op == OP_FORMAT) && (item.char_code == CH_TERM);
      go_new    = 1'b0;
      go_fail   = 1'b0;
      fail_term = 1'b0;
      fail_code = ERR_NONE;

      next_count = (NCW'(count_ff) << 3) + (NCW'(count_ff) << 1)
                   + NCW'(item.char_code - CH_ZERO);
      count = seen_ff ? count_ff : RCW'(1);
      esz = type_size(item.char_code);
      shift = esz[3] ? 2'd3 : (esz[2] ? 2'd2 : (esz[1] ? 2'd1 : 2'd0));
      limit = (CW'(buffer_bytes) > OFF_MAX) ? OFF_MAX : CW'(buffer_bytes);
      size = CW'(count) << shift;
      reach = CW'(woff_ff) + size;
      pend_dec = (pend_ff == '0) ? '0 : pend_ff - OFFSET_BITS'(1);

      bytes = '0;
      for (int k = 0; k < 8; k++) begin
         src = little_ff ? 3'(k) : 3'(ebytes_ff - 4'd1 - 4'(k));
         if (4'(k) < ebytes_ff) begin
            bytes[8*k +: 8] = item.value[8*src +: 8];
         end
      end

      if (step) begin
         unique case (phase_ff)
            PH_DISCARD: begin
               go_new = term;
            end
            PH_VALUES: begin
               if (item.op == OP_FORMAT) begin
                  go_fail   = 1'b1;
                  fail_code = ERR_OUT_OF_TURN;
                  fail_term = term;
               end else begin
                  emit = 1'b1;
                  word.kind   = KIND_DATA;
                  word.offset = FIELD_BITS'(woff_ff);
                  word.length = FIELD_BITS'(ebytes_ff);
                  word.data   = bytes;
                  woff_in = woff_ff + OFFSET_BITS'(ebytes_ff);
                  pend_in = pend_dec;
                  if (pend_dec == '0) begin
                     phase_in = PH_FORMAT;
                  end
               end
            end
            PH_FORMAT: begin
               if (item.op == OP_VALUE) begin
                  go_fail   = 1'b1;
                  fail_code = ERR_OUT_OF_TURN;
               end else if (first_ff && term) begin
                  go_fail   = 1'b1;
                  fail_code = ERR_EMPTY;
                  fail_term = 1'b1;
               end else if (first_ff && (item.char_code == CH_LITTLE ||
                            item.char_code == CH_BANG || item.char_code == CH_BIG)) begin
                  first_in  = 1'b0;
                  little_in = (item.char_code == CH_LITTLE);
               end else begin
                  first_in = 1'b0;
                  if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE) begin
                     count_in = (next_count > NCW'(CNT_SAT)) ? CNT_SAT : RCW'(next_count);
                     seen_in  = 1'b1;
                  end else if (seen_ff && count_ff == '0) begin
                     go_fail   = 1'b1;
                     fail_code = ERR_BAD_COUNT;
                     fail_term = term;
                  end else if (term) begin
                     if (seen_ff) begin
                        go_fail   = 1'b1;
                        fail_code = ERR_BAD_TYPE;
                        fail_term = 1'b1;
                     end else begin
                        emit = 1'b1;
                        word.kind   = KIND_DONE;
                        word.length = FIELD_BITS'(woff_ff);
                        go_new = 1'b1;
                     end
                  end else if (esz == 4'd0) begin
                     go_fail   = 1'b1;
                     fail_code = ERR_BAD_TYPE;
                  end else begin
                     count_in = '0;
                     seen_in  = 1'b0;
                     if (count[OFFSET_BITS] || reach > limit) begin
                        go_fail   = 1'b1;
                        fail_code = ERR_OVERFLOW;
                     end else if (item.char_code == CH_PAD) begin
                        emit = 1'b1;
                        word.kind   = KIND_FILL;
                        word.offset = FIELD_BITS'(woff_ff);
                        word.length = FIELD_BITS'(size);
                        woff_in = OFFSET_BITS'(reach);
                     end else begin
                        pend_in   = OFFSET_BITS'(count);
                        ebytes_in = esz;
                        phase_in  = PH_VALUES;
                     end
                  end
               end
            end
            default: begin
               go_new = 1'b1;
            end
         endcase
      end

      if (go_fail) begin
         emit = 1'b1;
         word = '{kind: KIND_ERROR, offset: FIELD_BITS'(woff_ff), length: '0,
                  data: '0, error_code: fail_code};
         if (fail_term) begin
            go_new = 1'b1;
         end else begin
            phase_in = PH_DISCARD;
         end
      end

      if (go_new) begin
         phase_in  = PH_FORMAT;
         little_in = 1'b0;
         count_in  = '0;
         seen_in   = 1'b0;
         pend_in   = '0;
         ebytes_in = '0;
         woff_in   = '0;
         first_in  = 1'b1;
      end
   end

endmodule
